>>> hdl/bvs_pkg.sv
// ----------------------------------------------------------------------------
// bvs_pkg
// shared types and constants for the bounded vector store
// ----------------------------------------------------------------------------
package bvs_pkg;

    localparam int CAPACITY = 64;
    localparam int IDX_W    = $clog2(CAPACITY);
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int DATA_W   = 32;

    typedef enum logic [2:0] {
        CMD_PUSH   = 3'd0,
        CMD_POP    = 3'd1,
        CMD_INSERT = 3'd2,
        CMD_ERASE  = 3'd3,
        CMD_RESIZE = 3'd4,
        CMD_READ   = 3'd5
    } t_cmd;

    typedef enum logic [1:0] {
        ST_DONE    = 2'd0,
        ST_INVALID = 2'd1,
        ST_FULL    = 2'd2
    } t_status;

    // broadcast from the controller to every cell
    typedef struct packed {
        logic                     push;
        logic                     ins;
        logic                     ers;
        logic                     grow;
        logic [IDX_W-1:0]         idx;
        logic [CNT_W-1:0]         cnt;
        logic [CNT_W-1:0]         req;
        logic signed [DATA_W-1:0] val;
    } t_cell_ctl;

endpackage

>>> hdl/bvs_cell.sv
// ----------------------------------------------------------------------------
// bvs_cell
// one element slot: holds, loads, zeroes or takes a neighbor's element
// ----------------------------------------------------------------------------
module bvs_cell
    import bvs_pkg::*;
(
    input  logic                     i_clk,
    input  logic [CNT_W-1:0]         i_pos,
    input  t_cell_ctl                i_ctl,
    input  logic signed [DATA_W-1:0] i_left,
    input  logic signed [DATA_W-1:0] i_right,
    output logic signed [DATA_W-1:0] o_data
);

    logic signed [DATA_W-1:0] r_data;
    logic signed [DATA_W-1:0] n_data;
    logic [CNT_W-1:0]         w_idx;
    logic [CNT_W-1:0]         w_pos_nx;

    assign w_idx    = CNT_W'(i_ctl.idx);
    assign w_pos_nx = CNT_W'(i_pos + CNT_W'(1));

    always_comb begin
        n_data = r_data;
        if (i_ctl.push && i_pos == i_ctl.cnt) begin
            n_data = i_ctl.val;
        end else if (i_ctl.ins && i_pos == w_idx) begin
            n_data = i_ctl.val;
        end else if (i_ctl.ins && i_pos > w_idx && i_pos <= i_ctl.cnt) begin
            n_data = i_left;
        end else if (i_ctl.ers && i_pos >= w_idx && w_pos_nx < i_ctl.cnt) begin
            n_data = i_right;
        end else if (i_ctl.grow && i_pos >= i_ctl.cnt && i_pos < i_ctl.req) begin
            n_data = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        r_data <= n_data;
    end

    assign o_data = r_data;

endmodule

>>> hdl/bvs_ctrl.sv
// ----------------------------------------------------------------------------
// bvs_ctrl
// command decode, element count and result registers
// ----------------------------------------------------------------------------
module bvs_ctrl
    import bvs_pkg::*;
(
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_accept,
    input  logic [2:0]               i_command,
    input  logic [IDX_W-1:0]         i_index,
    input  logic signed [DATA_W-1:0] i_value,
    input  logic [CNT_W-1:0]         i_new_size,
    input  logic signed [DATA_W-1:0] i_rd_elem,
    output t_cell_ctl                o_ctl,
    output logic                     o_valid,
    output logic signed [DATA_W-1:0] o_read_data,
    output logic [CNT_W-1:0]         o_length,
    output logic                     o_is_empty,
    output logic [1:0]               o_status
);

    logic                     r_valid;
    logic [CNT_W-1:0]         r_cnt;
    logic [CNT_W-1:0]         n_cnt;
    logic signed [DATA_W-1:0] r_rd;
    logic signed [DATA_W-1:0] n_rd;
    t_status                  r_status;
    t_status                  n_status;
    logic                     w_full;
    logic                     w_idx_ok;

    assign w_full   = (r_cnt >= CNT_W'(CAPACITY));
    assign w_idx_ok = (CNT_W'(i_index) < r_cnt);

    always_comb begin
        n_cnt      = r_cnt;
        n_rd       = '0;
        n_status   = ST_DONE;
        o_ctl      = '0;
        o_ctl.idx  = i_index;
        o_ctl.cnt  = r_cnt;
        o_ctl.req  = i_new_size;
        o_ctl.val  = i_value;
        unique case (t_cmd'(i_command))
            CMD_PUSH: begin
                if (w_full) begin
                    n_status = ST_FULL;
                end else begin
                    n_cnt      = CNT_W'(r_cnt + CNT_W'(1));
                    o_ctl.push = i_accept;
                end
            end
            CMD_POP: begin
                if (r_cnt == '0) begin
                    n_status = ST_INVALID;
                end else begin
                    n_cnt = CNT_W'(r_cnt - CNT_W'(1));
                end
            end
            CMD_INSERT: begin
                if (!w_idx_ok) begin
                    n_status = ST_INVALID;
                end else if (w_full) begin
                    n_status = ST_FULL;
                end else begin
                    n_cnt     = CNT_W'(r_cnt + CNT_W'(1));
                    o_ctl.ins = i_accept;
                end
            end
            CMD_ERASE: begin
                if (!w_idx_ok) begin
                    n_status = ST_INVALID;
                end else begin
                    n_cnt     = CNT_W'(r_cnt - CNT_W'(1));
                    o_ctl.ers = i_accept;
                end
            end
            CMD_RESIZE: begin
                if (i_new_size > CNT_W'(CAPACITY)) begin
                    n_status = ST_FULL;
                end else begin
                    n_cnt      = i_new_size;
                    o_ctl.grow = i_accept;
                end
            end
            CMD_READ: begin
                if (w_idx_ok) begin
                    n_rd = i_rd_elem;
                end else begin
                    n_rd     = '1;
                    n_status = ST_INVALID;
                end
            end
            default: begin
                n_status = ST_INVALID;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_cnt   <= '0;
        end else begin
            r_valid <= i_accept;
            if (i_accept) begin
                r_cnt <= n_cnt;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_accept) begin
            r_rd     <= n_rd;
            r_status <= n_status;
        end
    end

    assign o_valid     = r_valid;
    assign o_read_data = r_rd;
    assign o_length    = r_cnt;
    assign o_is_empty  = (r_cnt == '0);
    assign o_status    = r_status;

`ifndef SYNTH
    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CNT_W'(CAPACITY))
        else $error("element count above capacity");

    a_refused_keeps_cnt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid && r_status != ST_DONE) |-> (r_cnt == $past(r_cnt)))
        else $error("refused command changed the count");

    a_rd_only_on_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid && r_rd != '0) |-> ($past(i_command) == CMD_READ))
        else $error("read data set by a non-read command");

    a_strobe_follows_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid |-> $past(i_accept))
        else $error("result strobe without an accepted command");
`endif

endmodule

>>> hdl/bounded_vector_store_core.sv
// ----------------------------------------------------------------------------
// bounded_vector_store_core
// ordered list of up to CAPACITY signed 32-bit elements held in a row of cells
// ----------------------------------------------------------------------------
// usage
//   command channel: drive i_command, i_index, i_value, i_new_size and raise
//   start; the word is taken at the rising edge where start is high and busy
//   is low. busy is always low here, so a command can be issued every cycle.
//   result channel: o_valid is high for exactly one cycle, the cycle right
//   after the command was taken, with o_read_data, o_length, o_is_empty and
//   o_status. throughput is one command per cycle.
//   each element lives in its own cell; insert, erase and resize make every
//   cell load its left neighbor, right neighbor, the new value or zero at
//   the accept edge, so no command iterates over the list.
//   the receiver cannot stall: a result not taken in its strobe cycle is lost.
//   reset (i_rst_n low, synchronous) empties the list and drops any pending
//   strobe; element contents are left as they are, entries are only ever read
//   below the count.
// ----------------------------------------------------------------------------
module bounded_vector_store_core
    import bvs_pkg::*;
(
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     start,
    output logic                     busy,
    input  logic [2:0]               i_command,
    input  logic [IDX_W-1:0]         i_index,
    input  logic signed [DATA_W-1:0] i_value,
    input  logic [CNT_W-1:0]         i_new_size,
    output logic                     o_valid,
    output logic signed [DATA_W-1:0] o_read_data,
    output logic [CNT_W-1:0]         o_length,
    output logic                     o_is_empty,
    output logic [1:0]               o_status
);

    t_cell_ctl                w_ctl;
    logic                     w_accept;
    logic signed [DATA_W-1:0] w_data [CAPACITY];
    logic signed [DATA_W-1:0] w_rd_elem;

    // every command completes in the accept edge
    assign busy     = 1'b0;
    assign w_accept = start && !busy;

    // element at the requested index, used only by read
    assign w_rd_elem = w_data[i_index];

    bvs_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (w_accept),
        .i_command   (i_command),
        .i_index     (i_index),
        .i_value     (i_value),
        .i_new_size  (i_new_size),
        .i_rd_elem   (w_rd_elem),
        .o_ctl       (w_ctl),
        .o_valid     (o_valid),
        .o_read_data (o_read_data),
        .o_length    (o_length),
        .o_is_empty  (o_is_empty),
        .o_status    (o_status)
    );

    // row of cells, each wired to its neighbors, with zero beyond either end
    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        logic signed [DATA_W-1:0] w_left;
        logic signed [DATA_W-1:0] w_right;

        if (g == 0) begin : g_first
            assign w_left = '0;
        end else begin : g_mid_l
            assign w_left = w_data[g-1];
        end

        if (g == CAPACITY - 1) begin : g_last
            assign w_right = '0;
        end else begin : g_mid_r
            assign w_right = w_data[g+1];
        end

        bvs_cell u_cell (
            .i_clk   (i_clk),
            .i_pos   (CNT_W'(g)),
            .i_ctl   (w_ctl),
            .i_left  (w_left),
            .i_right (w_right),
            .o_data  (w_data[g])
        );
    end

endmodule
